// ----- rtl/core/dda_pkg.sv -----
package dda_pkg;

  localparam int FIELD_BITS         = 11;
  localparam int COORD_BITS_DEFAULT = 11;
  localparam int FRAC_BITS_DEFAULT  = 16;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic div_done;
    logic last;
  } ctrl_status_t;

endpackage

// ----- rtl/core/dda_div.sv -----
module dda_div #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  step,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] divisor,
  output logic [FRAC_BITS:0]    quotient_next
);
  import dda_pkg::*;

  logic [COORD_BITS:0]   rem;
  logic [FRAC_BITS:0]    quot;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic [COORD_BITS:0]   kept;

  // restoring division of mag * 2^FRAC_BITS by divisor, one quotient bit a cycle while step is high
  always_comb begin
    diff          = rem - {1'b0, divisor};
    ge            = (rem >= {1'b0, divisor});
    kept          = ge ? diff : rem;
    quotient_next = {quot[FRAC_BITS-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, mag};
      quot <= '0;
    end else if (step) begin
      rem  <= {kept[COORD_BITS-1:0], 1'b0};
      quot <= quotient_next;
    end
  end

endmodule

// ----- rtl/core/dda_datapath.sv -----
module dda_datapath #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  dda_pkg::in_item_t    in_item,
  input  dda_pkg::ctrl_cmd_t   cmd,
  output dda_pkg::ctrl_status_t status,
  output dda_pkg::out_item_t   out_item
);
  import dda_pkg::*;

  localparam int ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  logic [ACC_W-1:0]      acc_x;
  logic [ACC_W-1:0]      acc_y;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;
  logic [COORD_BITS:0]   pixels_left;
  logic [CNT_W-1:0]      div_cnt;
  logic                  neg_x;
  logic                  neg_y;
  logic [COORD_BITS-1:0] divisor;
  out_item_t             pixel;

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] ax, ay, steps;
  logic [FRAC_BITS:0]    qx_next, qy_next;
  logic [STEP_W-1:0]     incr_x, incr_y;
  logic [COORD_BITS-1:0] pos_x, pos_y;

  always_comb begin
    sx    = COORD_BITS'(in_item.start_x);
    sy    = COORD_BITS'(in_item.start_y);
    ex    = COORD_BITS'(in_item.end_x);
    ey    = COORD_BITS'(in_item.end_y);
    dx    = {1'b0, ex} - {1'b0, sx};
    dy    = {1'b0, ey} - {1'b0, sy};
    ax    = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
    ay    = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
    steps = (ax > ay) ? ax : ay;

    incr_x = neg_x ? (~{1'b0, qx_next} + 1'b1) : {1'b0, qx_next};
    incr_y = neg_y ? (~{1'b0, qy_next} + 1'b1) : {1'b0, qy_next};

    pos_x = acc_x[ACC_W-1:FRAC_BITS];
    pos_y = acc_y[ACC_W-1:FRAC_BITS];

    status.zero_len = (steps == '0);
    status.div_done = (div_cnt == CNT_W'(FRAC_BITS));
    status.last     = (pixels_left <= (COORD_BITS+1)'(1));
  end

  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_x (
    .clk           (clk),
    .start         (cmd.load),
    .step          (cmd.div_step),
    .mag           (ax),
    .divisor       (divisor),
    .quotient_next (qx_next)
  );

  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div_y (
    .clk           (clk),
    .start         (cmd.load),
    .step          (cmd.div_step),
    .mag           (ay),
    .divisor       (divisor),
    .quotient_next (qy_next)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_x       <= {sx, FRAC_BITS'(0)};
      acc_y       <= {sy, FRAC_BITS'(0)};
      step_x      <= '0;
      step_y      <= '0;
      pixels_left <= {1'b0, steps} + 1'b1;
      div_cnt     <= '0;
      neg_x       <= dx[COORD_BITS];
      neg_y       <= dy[COORD_BITS];
      divisor     <= steps;
    end else begin
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
        if (status.div_done) begin
          step_x <= incr_x;
          step_y <= incr_y;
        end
      end
      if (cmd.advance) begin
        acc_x <= acc_x + {{(ACC_W-STEP_W){step_x[STEP_W-1]}}, step_x};
        acc_y <= acc_y + {{(ACC_W-STEP_W){step_y[STEP_W-1]}}, step_y};
        pixels_left <= status.last ? '0 : pixels_left - 1'b1;
        pixel.pixel_x    <= FIELD_BITS'(pos_x);
        pixel.pixel_y    <= FIELD_BITS'(pos_y);
        pixel.last_pixel <= status.last;
      end
    end
  end

  assign out_item = pixel;

endmodule

// ----- rtl/core/dda_ctrl.sv -----
module dda_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  dda_pkg::ctrl_status_t status,
  output dda_pkg::ctrl_cmd_t    cmd
);
  import dda_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DRAW
  } state_t;

  state_t state;
  logic   accept;

  // a load may pass a held pixel; an advance needs the output slot
  always_comb begin
    in_stall = (state == ST_DIVIDE) ||
               (out_valid && out_stall && (in_command == CMD_ADVANCE));
    accept       = in_valid && !in_stall;
    cmd.load     = accept && (in_command == CMD_LOAD);
    cmd.advance  = accept && (in_command == CMD_ADVANCE) && (state == ST_DRAW);
    cmd.div_step = (state == ST_DIVIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= status.zero_len ? ST_DRAW : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (status.div_done) begin
            state <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (cmd.load) begin
            state <= status.zero_len ? ST_DRAW : ST_DIVIDE;
          end else if (cmd.advance && status.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/dda_line_rasterizer.sv -----
// DDA line rasterizer.
// Request channel cmd_*: command 0 loads start and end points, command 1
// asks for the next pixel. Pixel channel pix_*: one pixel per advance
// while a line is active, last_pixel set on the final one.
// A request is taken when valid is high and stall is low.
// After a load, cmd_stall is high while the two restoring dividers form
// the x and y increments one bit a cycle.
// A zero-length line skips the divide and gives its single start pixel.
// Advances are taken one per cycle; each pixel shows on pix_valid the cycle
// after its request. A line of step count S = max(|dx|, |dy|) gives S + 1
// pixels. An advance with no active line is taken and gives nothing.
// While pix_stall holds a pixel, advances stall but a load is still taken.
// A load during a line replaces that line at once.
// Reset leaves the block idle with no pixel pending.
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  dda_pkg::in_item_t   cmd_data,
  output logic                pix_valid,
  input  logic                pix_stall,
  output dda_pkg::out_item_t  pix_data
);
  import dda_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd_valid),
    .in_command (cmd_data.command),
    .in_stall   (cmd_stall),
    .out_valid  (pix_valid),
    .out_stall  (pix_stall),
    .status     (status),
    .cmd        (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .in_item  (cmd_data),
    .cmd      (cmd),
    .status   (status),
    .out_item (pix_data)
  );

endmodule

// ----- tb/dda_line_rasterizer_tb.sv -----
`timescale 1ns / 100ps

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int CB       = COORD_BITS_DEFAULT;
  localparam int FB       = FRAC_BITS_DEFAULT;
  localparam int ACCW     = CB + FB;
  localparam int CMASK    = (1 << CB) - 1;
  localparam int FMAX     = (1 << FIELD_BITS) - 1;
  localparam int NUM_REQS = 900;
  localparam int WATCHDOG = 2000;
  localparam int HOLD_LEN = 250;

  logic      clk;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_item_t  cmd_data  = '0;
  logic      pix_valid;
  logic      pix_stall = 1'b0;
  out_item_t pix_data;

  dda_line_rasterizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data)
  );

  in_item_t  req_q[$];
  out_item_t pending_pixels[$];

  // line state
  logic [ACCW-1:0] ln_acc_x, ln_acc_y;
  longint          ln_step_x, ln_step_y;
  int              ln_left;
  bit              ln_active;

  int n_reqs, n_loads, n_zero, n_adv, n_idle_adv, n_checked, n_last, errors;
  int n_gen, tx_wait, rx_wait, hold_cnt, holds, quiet;
  bit tx_calm, rx_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint increment(int d, int span);
    longint q;
    q = (longint'(d < 0 ? -d : d) << FB) / span;
    return d < 0 ? -q : q;
  endfunction

  task automatic rasterize(input in_item_t req);
    int        sx, sy, ex, ey, dx, dy, ax, ay, span;
    out_item_t px;
    if (req.command == CMD_LOAD) begin
      sx = int'(req.start_x) & CMASK;
      sy = int'(req.start_y) & CMASK;
      ex = int'(req.end_x) & CMASK;
      ey = int'(req.end_y) & CMASK;
      dx = ex - sx;
      dy = ey - sy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      span = ax > ay ? ax : ay;
      ln_acc_x = ACCW'(longint'(sx) << FB);
      ln_acc_y = ACCW'(longint'(sy) << FB);
      if (span == 0) begin
        ln_step_x = 0;
        ln_step_y = 0;
        n_zero++;
      end else begin
        ln_step_x = increment(dx, span);
        ln_step_y = increment(dy, span);
      end
      ln_left = span + 1;
      ln_active = 1'b1;
      n_loads++;
    end else if (!ln_active) begin
      n_idle_adv++;
    end else begin
      px.pixel_x = FIELD_BITS'(ln_acc_x >> FB);
      px.pixel_y = FIELD_BITS'(ln_acc_y >> FB);
      px.last_pixel = ln_left <= 1;
      pending_pixels.push_back(px);
      ln_acc_x = ACCW'(longint'(ln_acc_x) + ln_step_x);
      ln_acc_y = ACCW'(longint'(ln_acc_y) + ln_step_y);
      if (ln_left <= 1) begin
        ln_left = 0;
        ln_active = 1'b0;
      end else begin
        ln_left--;
      end
      n_adv++;
    end
  endtask

  task automatic push_raw(input bit force_cmd, input logic cmd);
    logic [63:0] r64;
    in_item_t    it;
    r64 = {$urandom(), $urandom()};
    it = r64[$bits(in_item_t)-1:0];
    if (force_cmd) it.command = cmd;
    req_q.push_back(it);
    n_gen++;
  endtask

  task automatic push_load(input int sx, input int sy, input int ex, input int ey);
    in_item_t it;
    it.command = CMD_LOAD;
    it.start_x = FIELD_BITS'(sx);
    it.start_y = FIELD_BITS'(sy);
    it.end_x   = FIELD_BITS'(ex);
    it.end_y   = FIELD_BITS'(ey);
    req_q.push_back(it);
    n_gen++;
  endtask

  task automatic push_adv(input int cnt);
    for (int i = 0; i < cnt; i++) push_raw(1'b1, CMD_ADVANCE);
  endtask

  function automatic int pick_end(int s, int reach);
    int d, e;
    if (reach >= FMAX) return $urandom_range(0, FMAX);
    d = $urandom_range(0, reach);
    e = $urandom_range(0, 1) ? s + d : s - d;
    if (e > FMAX) e = s - d;
    if (e < 0) e = s + d;
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!cmd_valid || !cmd_stall) begin
      if ($urandom_range(0, 49) == 0) tx_calm <= !tx_calm;
      if (tx_wait > 0) begin
        cmd_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (req_q.size() > 0) begin
        cmd_valid <= 1'b1;
        cmd_data <= req_q.pop_front();
        tx_wait <= tx_calm ? 0 : gap_len();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // pixel receiver, with long hold-offs to back up the request side
  always @(posedge clk) begin
    if (rst) begin
      pix_stall <= 1'b0;
      rx_wait <= 0;
      hold_cnt <= 0;
      holds <= 0;
    end else if (hold_cnt > 0) begin
      pix_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (holds < 2 && n_reqs >= 300 + 350 * holds) begin
      pix_stall <= 1'b1;
      hold_cnt <= HOLD_LEN;
      holds <= holds + 1;
    end else if (rx_wait > 0) begin
      pix_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      pix_stall <= 1'b0;
      if ($urandom_range(0, 49) == 0) rx_calm <= !rx_calm;
      if (!rx_calm && $urandom_range(0, 2) == 0) rx_wait <= gap_len();
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected pixel x=%0d y=%0d last=%0b", pix_data.pixel_x,
                     pix_data.pixel_y, pix_data.last_pixel);
        end else begin
          want = pending_pixels.pop_front();
          n_checked++;
          if (want.last_pixel) n_last++;
          if (pix_data.pixel_x !== want.pixel_x || pix_data.pixel_y !== want.pixel_y ||
              pix_data.last_pixel !== want.last_pixel) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: pixel %0d: x exp %0d got %0d, y exp %0d got %0d, last exp %0b got %0b",
                       n_checked, want.pixel_x, pix_data.pixel_x, want.pixel_y,
                       pix_data.pixel_y, want.last_pixel, pix_data.last_pixel);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        rasterize(cmd_data);
        n_reqs++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (pix_valid && !pix_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("dda_line_rasterizer test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int sx, sy, ex, ey, span, k, ax, ay;
    // directed: idle advances, zero-length lines, corner to corner, a full steep line
    push_adv(2);
    push_load(0, 0, 0, 0);
    push_adv(2);
    push_load(FMAX, FMAX, FMAX, FMAX);
    push_adv(1);
    push_load(0, 0, FMAX, FMAX);
    push_adv(2);
    push_load(FMAX, 0, 0, FMAX);
    push_adv(2);
    push_load(5, 3, 7, 12);
    push_adv(11);

    while (n_gen < NUM_REQS) begin
      if ($urandom_range(0, 99) < 80) begin
        sx = $urandom_range(0, FMAX);
        sy = $urandom_range(0, FMAX);
        k = $urandom_range(0, 99);
        span = k < 70 ? 12 : (k < 92 ? 150 : FMAX);
        ex = pick_end(sx, span);
        ey = pick_end(sy, span);
        ax = ex > sx ? ex - sx : sx - ex;
        ay = ey > sy ? ey - sy : sy - ey;
        span = ax > ay ? ax : ay;
        push_load(sx, sy, ex, ey);
        k = $urandom_range(0, 99);
        if (k < 70) k = span + 1;
        else if (k < 80) k = span + 1 + $urandom_range(1, 2);
        else k = $urandom_range(0, span);
        if (k > 160) k = $urandom_range(30, 60);
        push_adv(k);
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) push_raw(1'b0, CMD_LOAD);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (req_q.size() > 0 || cmd_valid);
    do @(posedge clk); while (pending_pixels.size() > 0);
    repeat (30) @(posedge clk);

    $display("Sent %0d requests: %0d loads (%0d zero-length), %0d advances, %0d while idle.",
             n_reqs, n_loads, n_zero, n_adv, n_idle_adv);
    $display("Checked %0d pixels and %0d line ends across %0d receiver hold-offs; %0d mismatches.",
             n_checked, n_last, holds, errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("dda_line_rasterizer test passed");
    end else begin
      $display("dda_line_rasterizer test failed");
    end
    $finish;
  end

endmodule

// ----- dda_line_rasterizer.f -----
rtl/core/dda_pkg.sv
rtl/core/dda_div.sv
rtl/core/dda_datapath.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_line_rasterizer.sv
tb/dda_line_rasterizer_tb.sv
